// File: rtl/arqs_pkg.sv
// ----------------------------------------------------------------------------
// arqs_pkg
// Types and codes shared by the run-queue scheduler modules.
// ----------------------------------------------------------------------------
package arqs_pkg;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_ENQUEUE  = 3'd1;
  localparam logic [2:0] OP_UNBLOCK  = 3'd2;
  localparam logic [2:0] OP_BLOCK    = 3'd3;
  localparam logic [2:0] OP_DEQUEUE  = 3'd4;
  localparam logic [2:0] OP_KILL     = 3'd5;
  localparam logic [2:0] OP_SCHEDULE = 3'd6;
  localparam logic [2:0] OP_UNUSED   = 3'd7;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_DEQUEUED = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_BLOCKED  = 3'd4;
  localparam logic [2:0] ST_KILLED   = 3'd5;

  localparam logic [3:0] AFF_ANY = 4'hF;

  typedef struct packed {
    logic [2:0]        operation;
    logic [5:0]        thread_slot;
    logic signed [3:0] affinity;
    logic [2:0]        cpu_index;
    logic              current_valid;
  } in_t;

  typedef struct packed {
    logic       picked_valid;
    logic [5:0] picked_slot;
    logic       outcome;
  } out_t;

  typedef struct packed {
    logic [2:0] status;
    logic       queued;
    logic [3:0] affinity;
  } slot_ent_t;

  localparam slot_ent_t SLOT_RESET = '{status: ST_FREE, queued: 1'b0, affinity: AFF_ANY};

endpackage

// File: rtl/arqs_slot_table.sv
// ----------------------------------------------------------------------------
// arqs_slot_table
// Per-slot status, queued mark and affinity; one registered read and one
// write per cycle, with a valid bit per entry standing in for the reset value.
// ----------------------------------------------------------------------------
module arqs_slot_table #(
  parameter int THREAD_SLOTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0] rd_addr_i,
  output arqs_pkg::slot_ent_t             rd_data_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(THREAD_SLOTS)-1:0] wr_addr_i,
  input  arqs_pkg::slot_ent_t             wr_data_i
);

  arqs_pkg::slot_ent_t     mem_q [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] valid_q;
  arqs_pkg::slot_ent_t     rdata_q;
  logic                    rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : arqs_pkg::SLOT_RESET;

endmodule

// File: rtl/affinity_run_queue_scheduler.sv
// ----------------------------------------------------------------------------
// affinity_run_queue_scheduler
// Active/expired run-queue thread scheduler over a fixed table of slots.
// ----------------------------------------------------------------------------
// Non-schedule operations: slot read in S_OP, result in S_DONE (an unused code or
// out-of-range slot goes straight to S_DONE). Schedule: S_QRD, S_QWT, S_EVAL per
// active-queue entry scanned (S_QRD, S_QWT only after the pick), then S_FIN, S_CEV
// for a valid current slot, S_DONE; reads walked by one sequencer. One item at a time.
// Reset: all slots free, both queues empty, queue A active; no clearing pass.
module affinity_run_queue_scheduler #(
  parameter int THREAD_SLOTS = 64,
  parameter int CPU_COUNT    = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  arqs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output arqs_pkg::out_t out_data_o
);

  localparam int SW = $clog2(THREAD_SLOTS);
  localparam int CW = $clog2(THREAD_SLOTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OP   = 4'd1;
  localparam logic [3:0] S_QRD  = 4'd2;
  localparam logic [3:0] S_QWT  = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_CEV  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  function automatic logic [SW-1:0] wrap_add(logic [SW-1:0] base, logic [CW-1:0] ofs);
    int sum;
    sum = int'(base) + int'(ofs);
    if (sum >= THREAD_SLOTS) begin
      sum = sum - THREAD_SLOTS;
    end
    return SW'(sum);
  endfunction

  logic [3:0]        state_q, state_d;
  arqs_pkg::in_t     req_q, req_d;
  logic [SW-1:0]     r_q, r_d, w_q, w_d;
  logic [CW-1:0]     k_q, k_d;
  logic              found_q, found_d;
  logic [SW-1:0]     ps_q, ps_d;
  logic              oc_q, oc_d;
  logic [SW-1:0]     head_a_q, head_a_d, head_b_q, head_b_d;
  logic [CW-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic              a_act_q, a_act_d;
  logic              out_valid_q, out_valid_d;
  arqs_pkg::out_t    out_q, out_d;

  logic [SW-1:0]     qa_mem [THREAD_SLOTS];
  logic [SW-1:0]     qb_mem [THREAD_SLOTS];
  logic [SW-1:0]     qa_rdata_q, qb_rdata_q;
  logic              q_re;
  logic [SW-1:0]     q_raddr;
  logic              qa_we, qb_we;
  logic [SW-1:0]     qa_waddr, qb_waddr, qa_wdata, qb_wdata;

  logic                sl_re, sl_we;
  logic [SW-1:0]       sl_raddr, sl_waddr;
  arqs_pkg::slot_ent_t sl_rdata, sl_wdata;

  logic              push_en;
  logic [SW-1:0]     push_slot;
  logic              keep_en;
  logic [SW-1:0]     keep_slot;
  logic              advance;

  logic [CW-1:0]     act_cnt, exp_cnt, new_cnt;
  logic [SW-1:0]     act_head, exp_head, exp_head_new;
  logic [SW-1:0]     q_t, s_idx;
  logic              s_ok, fit;
  logic [2:0]        st_next;

  assign act_cnt  = a_act_q ? cnt_a_q : cnt_b_q;
  assign exp_cnt  = a_act_q ? cnt_b_q : cnt_a_q;
  assign act_head = a_act_q ? head_a_q : head_b_q;
  assign exp_head = a_act_q ? head_b_q : head_a_q;
  assign exp_head_new = (exp_head == '0) ? SW'(THREAD_SLOTS - 1) : exp_head - SW'(1);
  assign q_t      = a_act_q ? qa_rdata_q : qb_rdata_q;
  assign s_idx    = SW'(req_q.thread_slot);
  assign s_ok     = int'(req_q.thread_slot) < THREAD_SLOTS;
  assign fit      = sl_rdata.affinity[3] ||
                    ((int'(req_q.cpu_index) < CPU_COUNT) &&
                     (sl_rdata.affinity[2:0] == req_q.cpu_index));
  assign st_next  = (sl_rdata.status == arqs_pkg::ST_RUNNING) ? arqs_pkg::ST_READY
                                                              : sl_rdata.status;

  arqs_slot_table #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (sl_re),
    .rd_addr_i (sl_raddr),
    .rd_data_o (sl_rdata),
    .wr_en_i   (sl_we),
    .wr_addr_i (sl_waddr),
    .wr_data_i (sl_wdata)
  );

  always_ff @(posedge clk_i) begin
    if (qa_we) begin
      qa_mem[qa_waddr] <= qa_wdata;
    end
    if (qb_we) begin
      qb_mem[qb_waddr] <= qb_wdata;
    end
    if (q_re) begin
      qa_rdata_q <= qa_mem[q_raddr];
      qb_rdata_q <= qb_mem[q_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    r_d         = r_q;
    w_d         = w_q;
    k_d         = k_q;
    found_d     = found_q;
    ps_d        = ps_q;
    oc_d        = oc_q;
    head_a_d    = head_a_q;
    head_b_d    = head_b_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    a_act_d     = a_act_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_re        = 1'b0;
    q_raddr     = wrap_add(act_head, CW'(r_q));
    sl_re       = 1'b0;
    sl_raddr    = s_idx;
    sl_we       = 1'b0;
    sl_waddr    = s_idx;
    sl_wdata    = sl_rdata;
    push_en     = 1'b0;
    push_slot   = s_idx;
    keep_en     = 1'b0;
    keep_slot   = q_t;
    advance     = 1'b0;
    new_cnt     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          found_d = 1'b0;
          ps_d    = '0;
          oc_d    = 1'b0;
          if (in_data_i.operation == arqs_pkg::OP_SCHEDULE) begin
            new_cnt = act_cnt;
            if (act_cnt == '0) begin
              a_act_d = !a_act_q;
              new_cnt = exp_cnt;
            end
            r_d = SW'(new_cnt - CW'(1));
            w_d = SW'(new_cnt - CW'(1));
            k_d = '0;
            state_d = (new_cnt == '0) ? S_FIN : S_QRD;
          end else if (in_data_i.operation == arqs_pkg::OP_UNUSED ||
                       int'(in_data_i.thread_slot) >= THREAD_SLOTS) begin
            oc_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            sl_re    = 1'b1;
            sl_raddr = SW'(in_data_i.thread_slot);
            state_d  = S_OP;
          end
        end
      end
      S_OP: begin
        sl_waddr = s_idx;
        state_d  = S_DONE;
        if (req_q.operation == arqs_pkg::OP_CREATE) begin
          if (sl_rdata.status == arqs_pkg::ST_FREE) begin
            sl_we    = 1'b1;
            sl_wdata = '{status: arqs_pkg::ST_DEQUEUED, queued: 1'b0,
                         affinity: $unsigned(req_q.affinity)};
          end else begin
            oc_d = 1'b1;
          end
        end else if (sl_rdata.status == arqs_pkg::ST_FREE) begin
          oc_d = 1'b1;
        end else begin
          case (req_q.operation)
            arqs_pkg::OP_ENQUEUE: begin
              if (sl_rdata.queued) begin
                oc_d = 1'b1;
              end else begin
                sl_we    = 1'b1;
                sl_wdata = '{status: arqs_pkg::ST_READY, queued: 1'b1,
                             affinity: sl_rdata.affinity};
                push_en  = 1'b1;
              end
            end
            arqs_pkg::OP_UNBLOCK: begin
              if (sl_rdata.status != arqs_pkg::ST_BLOCKED) begin
                oc_d = 1'b1;
              end else begin
                sl_we    = 1'b1;
                sl_wdata = '{status: arqs_pkg::ST_READY, queued: 1'b1,
                             affinity: sl_rdata.affinity};
                push_en  = !sl_rdata.queued;
              end
            end
            arqs_pkg::OP_BLOCK: begin
              sl_we           = 1'b1;
              sl_wdata.status = arqs_pkg::ST_BLOCKED;
            end
            arqs_pkg::OP_DEQUEUE: begin
              sl_we           = 1'b1;
              sl_wdata.status = arqs_pkg::ST_DEQUEUED;
            end
            arqs_pkg::OP_KILL: begin
              sl_we           = 1'b1;
              sl_wdata.status = arqs_pkg::ST_KILLED;
            end
            default: begin
              oc_d = 1'b1;
            end
          endcase
        end
      end
      S_QRD: begin
        q_re    = 1'b1;
        state_d = S_QWT;
      end
      S_QWT: begin
        if (found_q) begin
          keep_en = 1'b1;
          advance = 1'b1;
        end else begin
          sl_re    = 1'b1;
          sl_raddr = q_t;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        advance  = 1'b1;
        sl_waddr = q_t;
        if (!fit) begin
          keep_en = 1'b1;
        end else begin
          k_d   = k_q + CW'(1);
          sl_we = 1'b1;
          if (sl_rdata.status == arqs_pkg::ST_KILLED) begin
            sl_wdata = arqs_pkg::SLOT_RESET;
          end else if (sl_rdata.status == arqs_pkg::ST_READY) begin
            found_d  = 1'b1;
            ps_d     = q_t;
            sl_wdata = '{status: arqs_pkg::ST_RUNNING, queued: 1'b0,
                         affinity: sl_rdata.affinity};
          end else begin
            sl_wdata  = '{status: st_next, queued: 1'b1, affinity: sl_rdata.affinity};
            push_en   = 1'b1;
            push_slot = q_t;
          end
        end
      end
      S_FIN: begin
        if (a_act_q) begin
          head_a_d = wrap_add(head_a_q, k_q);
          cnt_a_d  = cnt_a_q - k_q;
        end else begin
          head_b_d = wrap_add(head_b_q, k_q);
          cnt_b_d  = cnt_b_q - k_q;
        end
        if (req_q.current_valid && s_ok) begin
          sl_re   = 1'b1;
          state_d = S_CEV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CEV: begin
        state_d = S_DONE;
        if (sl_rdata.status == arqs_pkg::ST_KILLED) begin
          if (!sl_rdata.queued) begin
            sl_we    = 1'b1;
            sl_wdata = arqs_pkg::SLOT_RESET;
          end
        end else if (sl_rdata.status != arqs_pkg::ST_FREE) begin
          sl_we    = 1'b1;
          sl_wdata = '{status: st_next, queued: 1'b1, affinity: sl_rdata.affinity};
          push_en  = !sl_rdata.queued;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.picked_valid = found_q;
          out_d.picked_slot  = found_q ? 6'(ps_q) : 6'd0;
          out_d.outcome      = oc_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (advance) begin
      if (r_q == '0) begin
        state_d = S_FIN;
      end else begin
        r_d     = r_q - SW'(1);
        state_d = S_QRD;
      end
    end

    qa_we    = 1'b0;
    qb_we    = 1'b0;
    qa_waddr = wrap_add(act_head, CW'(w_q));
    qb_waddr = wrap_add(act_head, CW'(w_q));
    qa_wdata = keep_slot;
    qb_wdata = keep_slot;

    if (keep_en) begin
      w_d = w_q - SW'(1);
      if (a_act_q) begin
        qa_we = 1'b1;
      end else begin
        qb_we = 1'b1;
      end
    end

    if (push_en && (int'(exp_cnt) < THREAD_SLOTS)) begin
      if (a_act_q) begin
        qb_we    = 1'b1;
        qb_waddr = exp_head_new;
        qb_wdata = push_slot;
        head_b_d = exp_head_new;
        cnt_b_d  = cnt_b_q + CW'(1);
      end else begin
        qa_we    = 1'b1;
        qa_waddr = exp_head_new;
        qa_wdata = push_slot;
        head_a_d = exp_head_new;
        cnt_a_d  = cnt_a_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      found_q     <= 1'b0;
      oc_q        <= 1'b0;
      head_a_q    <= '0;
      head_b_q    <= '0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      a_act_q     <= 1'b1;
      out_valid_q <= 1'b0;
      r_q         <= '0;
      w_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      oc_q        <= oc_d;
      head_a_q    <= head_a_d;
      head_b_q    <= head_b_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      a_act_q     <= a_act_d;
      out_valid_q <= out_valid_d;
      r_q         <= r_d;
      w_q         <= w_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    ps_q  <= ps_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_queue_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(cnt_a_q) <= THREAD_SLOTS) && (int'(cnt_b_q) <= THREAD_SLOTS))
    else $error("queue holds more entries than slots");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted item left sequencer idle");

  a_remove_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> k_q <= act_cnt)
    else $error("removed more entries than active queue held");

  a_pick_ends_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> !found_q)
    else $error("entry evaluated after a pick");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives create, enqueue, unblock, block, dequeue, kill, schedule and unused items
// into the run-queue scheduler, tracks slot table and both queues alongside it,
// and checks every result item field by field under varying idle and stall load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS = 64;
  localparam int CPUS  = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  arqs_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  arqs_pkg::out_t out_data_o;

  arqs_pkg::in_t  pending_items[$];
  arqs_pkg::out_t expected_results[$];
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   failed = 1'b0;

  logic [2:0] status_tbl [SLOTS];
  logic       queued_tbl [SLOTS];
  logic [3:0] aff_tbl    [SLOTS];
  logic [5:0] run_a[$];
  logic [5:0] run_b[$];
  bit         a_active;

  affinity_run_queue_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void release_slot(int s);
    status_tbl[s] = arqs_pkg::ST_FREE;
    queued_tbl[s] = 1'b0;
    aff_tbl[s] = arqs_pkg::AFF_ANY;
  endfunction

  function automatic void requeue_slot(int s);
    if (status_tbl[s] == arqs_pkg::ST_RUNNING) status_tbl[s] = arqs_pkg::ST_READY;
    if (!queued_tbl[s]) begin
      queued_tbl[s] = 1'b1;
      if (a_active) run_b.insert(0, 6'(s));
      else run_a.insert(0, 6'(s));
    end
  endfunction

  function automatic void add_item(arqs_pkg::in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic arqs_pkg::out_t scheduler_step(arqs_pkg::in_t it);
    arqs_pkg::out_t r;
    int s;
    int i;
    int t;
    logic [5:0] act[$];
    r = '0;
    s = it.thread_slot;
    if (it.operation == arqs_pkg::OP_SCHEDULE) begin
      if ((a_active ? run_a.size() : run_b.size()) == 0) a_active = !a_active;
      act = a_active ? run_a : run_b;
      i = act.size();
      while (i > 0) begin
        i--;
        t = act[i];
        if (!(aff_tbl[t][3] || (it.cpu_index < CPUS && aff_tbl[t] == 4'(it.cpu_index))))
          continue;
        act.delete(i);
        if (a_active) run_a = act;
        else run_b = act;
        queued_tbl[t] = 1'b0;
        if (status_tbl[t] == arqs_pkg::ST_KILLED) release_slot(t);
        else if (status_tbl[t] == arqs_pkg::ST_READY) begin
          r.picked_valid = 1'b1;
          r.picked_slot = 6'(t);
          break;
        end else requeue_slot(t);
        act = a_active ? run_a : run_b;
      end
      if (r.picked_valid) status_tbl[r.picked_slot] = arqs_pkg::ST_RUNNING;
      if (it.current_valid && status_tbl[s] != arqs_pkg::ST_FREE) begin
        if (status_tbl[s] == arqs_pkg::ST_KILLED) begin
          if (!queued_tbl[s]) release_slot(s);
        end else requeue_slot(s);
      end
    end else if (it.operation == arqs_pkg::OP_UNUSED) begin
      r.outcome = 1'b1;
    end else if (it.operation == arqs_pkg::OP_CREATE) begin
      if (status_tbl[s] == arqs_pkg::ST_FREE) begin
        status_tbl[s] = arqs_pkg::ST_DEQUEUED;
        queued_tbl[s] = 1'b0;
        aff_tbl[s] = it.affinity;
      end else r.outcome = 1'b1;
    end else if (status_tbl[s] == arqs_pkg::ST_FREE) begin
      r.outcome = 1'b1;
    end else begin
      case (it.operation)
        arqs_pkg::OP_ENQUEUE: begin
          if (queued_tbl[s]) r.outcome = 1'b1;
          else begin
            status_tbl[s] = arqs_pkg::ST_READY;
            requeue_slot(s);
          end
        end
        arqs_pkg::OP_UNBLOCK: begin
          if (status_tbl[s] != arqs_pkg::ST_BLOCKED) r.outcome = 1'b1;
          else begin
            status_tbl[s] = arqs_pkg::ST_READY;
            requeue_slot(s);
          end
        end
        arqs_pkg::OP_BLOCK:   status_tbl[s] = arqs_pkg::ST_BLOCKED;
        arqs_pkg::OP_DEQUEUE: status_tbl[s] = arqs_pkg::ST_DEQUEUED;
        default:              status_tbl[s] = arqs_pkg::ST_KILLED;
      endcase
    end
    return r;
  endfunction

  function automatic arqs_pkg::in_t make_item(logic [2:0] op, int s, int aff, int cpu,
                                              bit cv);
    arqs_pkg::in_t it;
    it.operation = op;
    it.thread_slot = 6'(s);
    it.affinity = 4'(aff);
    it.cpu_index = 3'(cpu);
    it.current_valid = cv;
    return it;
  endfunction

  function automatic arqs_pkg::in_t random_item(int pool);
    int pick;
    int aff;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 12) op = arqs_pkg::OP_CREATE;
    else if (pick < 30) op = arqs_pkg::OP_ENQUEUE;
    else if (pick < 36) op = arqs_pkg::OP_UNBLOCK;
    else if (pick < 42) op = arqs_pkg::OP_BLOCK;
    else if (pick < 46) op = arqs_pkg::OP_DEQUEUE;
    else if (pick < 51) op = arqs_pkg::OP_KILL;
    else if (pick < 98) op = arqs_pkg::OP_SCHEDULE;
    else op = arqs_pkg::OP_UNUSED;
    aff = ($urandom_range(2) == 0) ? -1 : $urandom_range(15);
    return make_item(op, $urandom_range(pool - 1), aff, $urandom_range(7),
                     $urandom_range(3) != 0);
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_results.insert(expected_results.size(), scheduler_step(in_data_i));
      void'(pending_items.pop_front());
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct && rst_ni) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end else in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    arqs_pkg::out_t exp_r;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation: %p", out_data_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data_o.picked_valid !== exp_r.picked_valid) begin
          $error("picked_valid expected %0d actual %0d", exp_r.picked_valid,
                 out_data_o.picked_valid);
          failed = 1'b1;
        end
        if (out_data_o.picked_slot !== exp_r.picked_slot) begin
          $error("picked_slot expected %0d actual %0d", exp_r.picked_slot,
                 out_data_o.picked_slot);
          failed = 1'b1;
        end
        if (out_data_o.outcome !== exp_r.outcome) begin
          $error("outcome expected %0d actual %0d", exp_r.outcome, out_data_o.outcome);
          failed = 1'b1;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    int n;
    int cnt;
    for (n = 0; n < SLOTS; n++) release_slot(n);
    a_active = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every operation, special cases
    add_item(make_item(arqs_pkg::OP_ENQUEUE, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 63, 0, 7, 1'b1));
    add_item(make_item(arqs_pkg::OP_CREATE, 0, -1, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_CREATE, 63, 7, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_CREATE, 5, 3, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_CREATE, 5, 2, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_UNBLOCK, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_ENQUEUE, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_ENQUEUE, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_ENQUEUE, 63, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_ENQUEUE, 5, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_BLOCK, 5, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_UNBLOCK, 5, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_KILL, 63, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 0, 0, 7, 1'b1));
    add_item(make_item(arqs_pkg::OP_DEQUEUE, 5, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 5, 0, 3, 1'b1));
    add_item(make_item(arqs_pkg::OP_KILL, 0, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 0, 0, 3, 1'b1));
    add_item(make_item(arqs_pkg::OP_UNUSED, 5, 0, 0, 1'b0));
    add_item(make_item(arqs_pkg::OP_SCHEDULE, 5, 0, 3, 1'b1));
    while (pending_items.size() > 0) @(posedge clk_i);
    // random phases: none, sender idle, receiver stall, both
    for (n = 0; n < 4; n++) begin
      idle_pct = (n == 1) ? 68 : (n == 3) ? 11 : 0;
      stall_pct = (n == 2) ? 68 : (n == 3) ? 11 : 0;
      for (cnt = 0; cnt < 310; cnt++)
        add_item(random_item((n == 0) ? 12 : 64));
      while (pending_items.size() > 0) @(posedge clk_i);
    end
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
